// File: hdl/flgr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flgr_pkg: shared types and constants of the feedback flanger
// configuration fields and reset values, controller states and commands,
// datapath status, fixed-point limits, sine constants, saturation helper
// ----------------------------------------------------------------------------
package flgr_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int PHASE_W     = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int DCALC_W     = 24;  // signed width of the delay arithmetic

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BASE_DELAY    = 3'd0,
    REG_DEPTH_DELAY   = 3'd1,
    REG_PHASE_STEP    = 3'd2,
    REG_FEEDBACK_GAIN = 3'd3,
    REG_MANUAL_OFFSET = 3'd4,
    REG_MIX_GAIN      = 3'd5,
    REG_MAX_DELAY     = 3'd6
  } cfg_reg_t;

  // reset values
  localparam logic [17:0] BASE_DELAY_RST    = 18'd14746;
  localparam logic [17:0] DEPTH_DELAY_RST   = 18'd19661;
  localparam logic [31:0] PHASE_STEP_RST    = 32'd31317;
  localparam logic [15:0] FEEDBACK_GAIN_RST = 16'd13107;
  localparam logic [15:0] MANUAL_OFFSET_RST = 16'd0;
  localparam logic [15:0] MIX_GAIN_RST      = 16'd16384;
  localparam logic [17:0] MAX_DELAY_RST     = 18'd245760;

  // fixed-point limits
  localparam logic signed [15:0]        FB_LIMIT  = 16'sd31130;
  localparam logic [15:0]               MIX_FULL  = 16'd32768;
  localparam logic signed [DCALC_W-1:0] MIN_DELAY = 24'sd256;

  // sine table generation, quarter-wave argument scaled to Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV [1:6] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

  typedef struct packed {
    logic [17:0]        base_delay;
    logic [17:0]        depth_delay;
    logic [31:0]        phase_step;
    logic signed [15:0] feedback_gain;
    logic signed [15:0] manual_offset;
    logic [15:0]        mix_gain;
    logic [17:0]        max_delay;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SINE,
    ST_DEPTH,
    ST_DELAY,
    ST_TAP0,
    ST_TAP1,
    ST_INTERP,
    ST_WET,
    ST_PRODUCT,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic accept;   // latch input, look up sine index, advance phase
    logic sine;     // sine table read
    logic depth;    // depth times lfo
    logic delay;    // delay sum and clamp
    logic tap0;     // read newer tap
    logic tap1;     // read older tap
    logic interp;   // fraction times tap difference
    logic wet;      // interpolated sample
    logic product;  // feedback and mix products
    logic commit;   // write back, advance position, load output
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_blocked;  // output register full and not taken this cycle
  } dp_status_t;

  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    if (v > 40'sd32767) begin
      sat16 = 16'sh7fff;
    end else if (v < -40'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

endpackage

// File: hdl/flgr_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flgr_in_if: dry sample stream
// valid/ready channel carrying one channel-tagged audio sample per transfer
// ----------------------------------------------------------------------------
interface flgr_in_if;
  logic                                valid;
  logic                                ready;
  logic                                channel;
  logic signed [flgr_pkg::SAMPLE_W-1:0] sample_in;

  modport source(output valid, channel, sample_in, input ready);
  modport sink(input valid, channel, sample_in, output ready);
endinterface

// File: hdl/flgr_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flgr_out_if: processed sample stream
// valid/ready channel carrying one channel-tagged result sample per transfer
// ----------------------------------------------------------------------------
interface flgr_out_if;
  logic                                valid;
  logic                                ready;
  logic                                channel_out;
  logic signed [flgr_pkg::SAMPLE_W-1:0] sample_out;

  modport source(output valid, channel_out, sample_out, input ready);
  modport sink(input valid, channel_out, sample_out, output ready);
endinterface

// File: hdl/feedback_flanger.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feedback_flanger: multi-channel flanger with feedback and sine lfo
// channel-tagged samples in, one mixed sample out per input sample
// ----------------------------------------------------------------------------
// usage
//   samples: one transfer per dry sample (channel, sample_in)
//   results: one transfer per processed sample (channel_out, sample_out),
//     in input order
//   cfg_write/cfg_index/cfg_data: register writes, to be issued only while
//     no sample is in flight
// timing
//   a sample is taken only while the block is idle, so no new sample is
//   taken before the last one is written back; the step sequencer walks
//   the single-port delay store (two tap reads, one write back) and the
//   multiplier steps one after another
// reset
//   registers return to their defaults, lfo phases and write positions go
//   to zero; each delay line reads as silence until written, tracked by a
//   per-channel fill mark, so no clearing pass is needed
// stall
//   the finished result waits in the output register; the next sample is
//   taken and processed meanwhile and holds at write back until the
//   receiver takes the waiting result
// ----------------------------------------------------------------------------
module feedback_flanger #(
  parameter int DELAY_DEPTH     = 1024,
  parameter int CHANNELS        = 2,
  parameter int SINE_TABLE_SIZE = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  flgr_in_if.sink                           samples,
  flgr_out_if.source                        results,
  input  logic                              cfg_write,
  input  logic [flgr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [flgr_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import flgr_pkg::*;

  cfg_t       cfg;      // current register values
  ctrl_cmd_t  cmd;      // at most one step per cycle from the sequencer
  dp_status_t status;   // output register occupancy
  logic       in_ready;

  // register file
  flgr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer, takes a sample only when idle
  flgr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  assign samples.ready = in_ready;

  // lfo, delay lines, interpolation, feedback and mix
  flgr_dp #(
    .DELAY_DEPTH     (DELAY_DEPTH),
    .CHANNELS        (CHANNELS),
    .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg        (cfg),
    .in_channel (samples.channel),
    .in_sample  (samples.sample_in),
    .status     (status),
    .results    (results)
  );

endmodule

// File: hdl/flgr_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flgr_cfg: configuration register file
// write-only registers loaded by index, unknown indexes are dropped
// ----------------------------------------------------------------------------
module flgr_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [flgr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [flgr_pkg::CFG_DATA_W-1:0]   cfg_data,
  output flgr_pkg::cfg_t                    cfg
);
  import flgr_pkg::*;

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.base_delay    <= BASE_DELAY_RST;
      regs.depth_delay   <= DEPTH_DELAY_RST;
      regs.phase_step    <= PHASE_STEP_RST;
      regs.feedback_gain <= FEEDBACK_GAIN_RST;
      regs.manual_offset <= MANUAL_OFFSET_RST;
      regs.mix_gain      <= MIX_GAIN_RST;
      regs.max_delay     <= MAX_DELAY_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BASE_DELAY:    regs.base_delay    <= cfg_data[17:0];
        REG_DEPTH_DELAY:   regs.depth_delay   <= cfg_data[17:0];
        REG_PHASE_STEP:    regs.phase_step    <= cfg_data[31:0];
        REG_FEEDBACK_GAIN: regs.feedback_gain <= cfg_data[15:0];
        REG_MANUAL_OFFSET: regs.manual_offset <= cfg_data[15:0];
        REG_MIX_GAIN:      regs.mix_gain      <= cfg_data[15:0];
        REG_MAX_DELAY:     regs.max_delay     <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

// File: hdl/flgr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flgr_ctrl: sequencing state machine
// walks one sample through the datapath steps, holds at write back while
// the output register is still occupied
// ----------------------------------------------------------------------------
module flgr_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  flgr_pkg::dp_status_t    status,
  output flgr_pkg::ctrl_cmd_t     cmd
);
  import flgr_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (in_valid) state_next = ST_SINE;
      ST_SINE:    state_next = ST_DEPTH;
      ST_DEPTH:   state_next = ST_DELAY;
      ST_DELAY:   state_next = ST_TAP0;
      ST_TAP0:    state_next = ST_TAP1;
      ST_TAP1:    state_next = ST_INTERP;
      ST_INTERP:  state_next = ST_WET;
      ST_WET:     state_next = ST_PRODUCT;
      ST_PRODUCT: state_next = ST_WRITE;
      ST_WRITE:   if (!status.out_blocked) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_SINE:    cmd.sine    = 1'b1;
      ST_DEPTH:   cmd.depth   = 1'b1;
      ST_DELAY:   cmd.delay   = 1'b1;
      ST_TAP0:    cmd.tap0    = 1'b1;
      ST_TAP1:    cmd.tap1    = 1'b1;
      ST_INTERP:  cmd.interp  = 1'b1;
      ST_WET:     cmd.wet     = 1'b1;
      ST_PRODUCT: cmd.product = 1'b1;
      ST_WRITE:   cmd.commit  = !status.out_blocked;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // at most one datapath step per cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command");

  // a sample in flight blocks the next transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> !in_ready)
    else $error("input ready right after a transfer");

  // write back frees the block
  a_ready_after_commit: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> in_ready)
    else $error("block not ready after write back");
`endif

endmodule

// File: hdl/flgr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flgr_dp: flanger datapath
// per-channel lfo phase and delay line, sine table, delay clamp, two-tap
// interpolation, feedback write back and wet/dry mix with output register
// ----------------------------------------------------------------------------
module flgr_dp #(
  parameter int DELAY_DEPTH     = 1024,
  parameter int CHANNELS        = 2,
  parameter int SINE_TABLE_SIZE = 256
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  flgr_pkg::ctrl_cmd_t                   cmd,
  input  flgr_pkg::cfg_t                        cfg,
  input  logic                                  in_channel,
  input  logic signed [flgr_pkg::SAMPLE_W-1:0]  in_sample,
  output flgr_pkg::dp_status_t                  status,
  flgr_out_if.source                            results
);
  import flgr_pkg::*;

  localparam int AW        = $clog2(DELAY_DEPTH);
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MEM_DEPTH = CHANNELS * DELAY_DEPTH;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int TW        = $clog2(SINE_TABLE_SIZE);
  localparam int CAP       = (DELAY_DEPTH - 1) * 256;

  // sine of table entry idx, Q1.15, quadrant fold and Taylor series in Q30
  function automatic logic signed [15:0] sine_entry(input int unsigned idx);
    logic [63:0]        a;
    logic [63:0]        r;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [1:0]         q;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    int                 n;
    a = (64'(idx) << 32) / SINE_TABLE_SIZE;
    q = a[31:30];
    r = {34'd0, a[29:0]};
    if (q[0]) r = 64'h4000_0000 - r;
    x    = (r * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n];
      if (n % 2 == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    v = (sum + 64'sd16384) >>> 15;
    if (v > 64'sd32767) v = 64'sd32767;
    sine_entry = q[1] ? 16'(-v) : 16'(v);
  endfunction

  function automatic logic [MEM_AW-1:0] mem_index(input logic [CH_W-1:0] c,
                                                  input logic [AW-1:0] a);
    mem_index = MEM_AW'(32'(c) * DELAY_DEPTH + 32'(a));
  endfunction

  // sine rom
  logic signed [15:0] sine_tab [SINE_TABLE_SIZE];
  for (genvar gi = 0; gi < SINE_TABLE_SIZE; gi++) begin : g_sine
    localparam logic signed [15:0] ENTRY = sine_entry(gi);
    assign sine_tab[gi] = ENTRY;
  end

  // delay store
  logic signed [15:0] mem [MEM_DEPTH];

  // per-channel state
  logic [PHASE_W-1:0] phase   [CHANNELS];
  logic [AW-1:0]      wp      [CHANNELS];
  logic               wrapped [CHANNELS];

  // pipeline payload
  logic                      chbit_q;
  logic signed [15:0]        dry_q;
  logic [TW-1:0]             k_q;
  logic signed [15:0]        sine_q;
  logic signed [35:0]        dmod_q;
  logic [AW-1:0]             n_q;
  logic [7:0]                f_q;
  logic signed [15:0]        rd_q;
  logic                      rd_ok_q;
  logic signed [15:0]        x0_q;
  logic signed [25:0]        interp_q;
  logic signed [16:0]        wet_q;
  logic signed [32:0]        fb_prod_q;
  logic signed [33:0]        mix_a_q;
  logic signed [32:0]        mix_b_q;

  // output register
  logic                      out_valid;
  logic                      out_channel;
  logic signed [15:0]        out_sample;

  // combinational
  logic [CH_W-1:0]           ch_in;
  logic [CH_W-1:0]           ch_q;
  logic [PHASE_W-1:0]        phase_in;
  logic [PHASE_W+TW-1:0]     k_prod;
  logic [AW-1:0]             wp_cur;
  logic                      wrapped_cur;
  logic signed [16:0]        lfo;
  logic signed [36:0]        dmod_round;
  logic signed [DCALC_W-1:0] upper_lim;
  logic signed [DCALC_W-1:0] d_raw;
  logic signed [DCALC_W-1:0] d_clamp;
  logic [AW:0]               n1;
  logic [AW-1:0]             addr0;
  logic [AW-1:0]             addr1;
  logic [AW-1:0]             rd_addr;
  logic signed [15:0]        x1;
  logic signed [16:0]        diff;
  logic signed [15:0]        fb_gain;
  logic [15:0]               mix_c;
  logic [15:0]               dry_w;
  logic signed [33:0]        fb_sum;
  logic signed [34:0]        mix_sum;
  logic signed [15:0]        fbw;
  logic signed [15:0]        y;

  assign ch_in = (CHANNELS > 1) ? CH_W'(in_channel) : '0;
  assign ch_q  = (CHANNELS > 1) ? CH_W'(chbit_q) : '0;

  assign phase_in = phase[ch_in];
  assign k_prod   = {{TW{1'b0}}, phase_in} * (PHASE_W + TW)'(SINE_TABLE_SIZE);

  assign wp_cur      = wp[ch_q];
  assign wrapped_cur = wrapped[ch_q];

  assign lfo        = 17'(sine_q) + 17'(cfg.manual_offset);
  assign dmod_round = 37'(dmod_q) + 37'sd16384;

  always_comb begin
    upper_lim = $signed({{(DCALC_W-18){1'b0}}, cfg.max_delay});
    if (upper_lim > DCALC_W'(CAP)) upper_lim = DCALC_W'(CAP);
    if (upper_lim < MIN_DELAY) upper_lim = MIN_DELAY;
    d_raw   = $signed({{(DCALC_W-18){1'b0}}, cfg.base_delay}) + DCALC_W'(dmod_round >>> 15);
    d_clamp = d_raw;
    if (d_clamp < MIN_DELAY) d_clamp = MIN_DELAY;
    if (d_clamp > upper_lim) d_clamp = upper_lim;
  end

  // taps n and n+1 samples behind the write position, modulo the line length
  assign n1    = {1'b0, n_q} + 1'b1;
  assign addr0 = (wp_cur >= n_q) ? AW'(wp_cur - n_q)
               : AW'({1'b0, wp_cur} + (AW+1)'(DELAY_DEPTH) - {1'b0, n_q});
  assign addr1 = ({1'b0, wp_cur} >= n1) ? AW'({1'b0, wp_cur} - n1)
               : AW'({1'b0, wp_cur} + (AW+1)'(DELAY_DEPTH) - n1);
  assign rd_addr = cmd.tap1 ? addr1 : addr0;

  assign x1   = rd_ok_q ? rd_q : '0;
  assign diff = 17'(x1) - 17'(x0_q);

  always_comb begin
    fb_gain = cfg.feedback_gain;
    if (fb_gain > FB_LIMIT) fb_gain = FB_LIMIT;
    if (fb_gain < -FB_LIMIT) fb_gain = -FB_LIMIT;
  end

  assign mix_c = (cfg.mix_gain > MIX_FULL) ? MIX_FULL : cfg.mix_gain;
  assign dry_w = MIX_FULL - mix_c;

  assign fb_sum  = 34'(fb_prod_q) + 34'sd16384;
  assign fbw     = sat16(40'(fb_sum >>> 15) + 40'(dry_q));
  assign mix_sum = 35'(mix_a_q) + 35'(mix_b_q) + 35'sd16384;
  assign y       = sat16(40'(mix_sum >>> 15));

  // arithmetic steps
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      chbit_q <= in_channel;
      dry_q   <= in_sample;
      k_q     <= k_prod[PHASE_W +: TW];
    end
    if (cmd.sine) sine_q <= sine_tab[k_q];
    if (cmd.depth) dmod_q <= $signed({1'b0, cfg.depth_delay}) * lfo;
    if (cmd.delay) begin
      n_q <= d_clamp[8 +: AW];
      f_q <= d_clamp[7:0];
    end
    if (cmd.tap1) x0_q <= rd_ok_q ? rd_q : '0;
    if (cmd.interp) interp_q <= $signed({1'b0, f_q}) * diff;
    if (cmd.wet) wet_q <= 17'(x0_q) + 17'((interp_q + 26'sd128) >>> 8);
    if (cmd.product) begin
      fb_prod_q <= wet_q * fb_gain;
      mix_a_q   <= wet_q * $signed({1'b0, mix_c});
      mix_b_q   <= dry_q * $signed({1'b0, dry_w});
    end
  end

  // delay store read, entries past the fill mark read as silence
  always_ff @(posedge clk) begin
    if (cmd.tap0 || cmd.tap1) begin
      rd_q    <= mem[mem_index(ch_q, rd_addr)];
      rd_ok_q <= wrapped_cur || (rd_addr < wp_cur);
    end
  end

  // feedback write back
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      mem[mem_index(ch_q, wp_cur)] <= fbw;
    end
  end

  // phase, write position and fill mark
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        phase[c]   <= '0;
        wp[c]      <= '0;
        wrapped[c] <= 1'b0;
      end
    end else begin
      if (cmd.accept) phase[ch_in] <= phase_in + cfg.phase_step;
      if (cmd.commit) begin
        if (32'(wp_cur) == DELAY_DEPTH - 1) begin
          wp[ch_q]      <= '0;
          wrapped[ch_q] <= 1'b1;
        end else begin
          wp[ch_q] <= wp_cur + 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_channel <= chbit_q;
      out_sample  <= y;
    end
  end

  assign results.valid       = out_valid;
  assign results.channel_out = out_channel;
  assign results.sample_out  = out_sample;

  assign status.out_blocked = out_valid && !results.ready;

`ifndef SYNTHESIS
  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(out_valid && !results.ready))
    else $error("write back while output register is occupied");

  // every result comes from a write back
  a_valid_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("result appeared without a write back");

  // write position stays inside the line
  a_wp_range: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (32'(wp_cur) < DELAY_DEPTH))
    else $error("write position beyond delay line");
`endif

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the feedback flanger
// a short table of directed samples and register writes, then random phases
// with fresh register settings; every result transfer is compared against its
// hand-derived value or a bit-accurate model stepped with each accepted sample
// ----------------------------------------------------------------------------
module testbench;
  import flgr_pkg::*;

  localparam int DEPTH       = 1024;
  localparam int CHANNELS    = 2;
  localparam int SINE_SIZE   = 256;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 12;    // cycles after the last result before a write
  localparam int TAIL        = 40;    // cycles after the last result at the end
  localparam int MAX_REPORTS = 10;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 142;
  localparam int HOLD_AT     = 230;   // result count at which the sink holds off
  localparam int HOLD_CYCLES = 400;
  localparam int PAUSE_PHASE = 3;     // phase in which the sender drains midway

  // index with no register behind it, writes are dropped
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic               ch;
    logic signed [15:0] smp;
  } flange_out_t;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_INDEX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0]   data;
    logic                    ch;
    logic signed [15:0]      smp;
    logic                    typed;  // want holds a hand-derived result
    logic signed [15:0]      want;
  } dir_row_t;

  localparam int NROWS = 40;

  // directed stimulus: the first rows run on an all-silent delay store, so the
  // results there follow directly from the dry share of the mix
  dir_row_t dir_rows [NROWS] = '{
    '{ROW_SAMPLE, 3'd0, 32'd0, 1'b0, 16'sh7fff, 1'b1, 16'sh4000},
    '{ROW_SAMPLE, 3'd0, 32'd0, 1'b1, 16'sh8000, 1'b1, 16'shc000},
    '{ROW_SAMPLE, 3'd0, 32'd0, 1'b0, 16'sh0000, 1'b1, 16'sh0000},
    '{ROW_CFG, REG_MIX_GAIN, 32'd0, 1'b0, 16'sh0, 1'b0, 16'sh0},
    '{ROW_SAMPLE, 3'd0, 32'd0, 1'b1, 16'sd12345, 1'b1, 16'sd12345},
    '{ROW_SAMPLE, 3'd0, 32'd0, 1'b0, 16'shffff, 1'b1, 16'shffff},
    '{ROW_CFG, REG_MIX_GAIN, 32'h0000_ffff, 1'b0, 16'sh0, 1'b0, 16'sh0},
    '{ROW_SAMPLE, 3'd0, 32'd0, 1'b0, 16'sh7fff, 1'b1, 16'sh0000},
    '{ROW_SAMPLE, 3'd0, 32'd0, 1'b1, 16'sh8000, 1'b1, 16'sh0000},
    '{ROW_CFG, REG_UNUSED, 32'hffff_ffff, 1'b0, 16'sh0, 1'b0, 16'sh0},
    '{ROW_SAMPLE, 3'd0, 32'd0, 1'b0, 16'sd1000, 1'b0, 16'sh0},
    '{ROW_CFG, REG_BASE_DELAY, 32'd0, 1'b0, 16'sh0, 1'b0, 16'sh0},
    '{ROW_CFG, REG_DEPTH_DELAY, 32'd0, 1'b0, 16'sh0, 1'b0, 16'sh0},
    '{ROW_CFG, REG_MAX_DELAY, 32'd0, 1'b0, 16'sh0, 1'b0, 16'sh0},
    '{ROW_CFG, REG_FEEDBACK_GAIN, 32'h0000_7fff, 1'b0, 16'sh0, 1'b0, 16'sh0},
    '{ROW_SAMPLE, 3'd0, 32'd0, 1'b0, 16'sh7fff, 1'b0, 16'sh0},
    '{ROW_SAMPLE, 3'd0, 32'd0, 1'b0, 16'sh7fff, 1'b0, 16'sh0},
    '{ROW_SAMPLE, 3'd0, 32'd0, 1'b0, 16'sh7fff, 1'b0, 16'sh0},
    '{ROW_SAMPLE, 3'd0, 32'd0, 1'b0, 16'sh7fff, 1'b0, 16'sh0},
    '{ROW_CFG, REG_FEEDBACK_GAIN, 32'h0000_8000, 1'b0, 16'sh0, 1'b0, 16'sh0},
    '{ROW_SAMPLE, 3'd0, 32'd0, 1'b0, 16'sh8000, 1'b0, 16'sh0},
    '{ROW_SAMPLE, 3'd0, 32'd0, 1'b0, 16'sh8000, 1'b0, 16'sh0},
    '{ROW_CFG, REG_MIX_GAIN, 32'd32768, 1'b0, 16'sh0, 1'b0, 16'sh0},
    '{ROW_CFG, REG_MANUAL_OFFSET, 32'h0000_7fff, 1'b0, 16'sh0, 1'b0, 16'sh0},
    '{ROW_CFG, REG_DEPTH_DELAY, 32'd261888, 1'b0, 16'sh0, 1'b0, 16'sh0},
    '{ROW_CFG, REG_BASE_DELAY, 32'd261888, 1'b0, 16'sh0, 1'b0, 16'sh0},
    '{ROW_CFG, REG_MAX_DELAY, 32'h0003_ffff, 1'b0, 16'sh0, 1'b0, 16'sh0},
    '{ROW_SAMPLE, 3'd0, 32'd0, 1'b1, 16'sd20000, 1'b0, 16'sh0},
    '{ROW_SAMPLE, 3'd0, 32'd0, 1'b1, 16'shb1e0, 1'b0, 16'sh0},
    '{ROW_CFG, REG_MANUAL_OFFSET, 32'h0000_8000, 1'b0, 16'sh0, 1'b0, 16'sh0},
    '{ROW_CFG, REG_BASE_DELAY, 32'd0, 1'b0, 16'sh0, 1'b0, 16'sh0},
    '{ROW_CFG, REG_PHASE_STEP, 32'hffff_ffff, 1'b0, 16'sh0, 1'b0, 16'sh0},
    '{ROW_SAMPLE, 3'd0, 32'd0, 1'b0, 16'sd5, 1'b0, 16'sh0},
    '{ROW_SAMPLE, 3'd0, 32'd0, 1'b1, 16'shfffb, 1'b0, 16'sh0},
    '{ROW_SAMPLE, 3'd0, 32'd0, 1'b0, 16'sh7fff, 1'b0, 16'sh0},
    '{ROW_SAMPLE, 3'd0, 32'd0, 1'b1, 16'sh8000, 1'b0, 16'sh0},
    '{ROW_CFG, REG_PHASE_STEP, 32'd0, 1'b0, 16'sh0, 1'b0, 16'sh0},
    '{ROW_CFG, REG_FEEDBACK_GAIN, 32'd0, 1'b0, 16'sh0, 1'b0, 16'sh0},
    '{ROW_SAMPLE, 3'd0, 32'd0, 1'b0, 16'sd1234, 1'b0, 16'sh0},
    '{ROW_SAMPLE, 3'd0, 32'd0, 1'b1, 16'shfb2e, 1'b0, 16'sh0}
  };

  logic clk;
  logic rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  flgr_in_if  sample_bus ();
  flgr_out_if result_bus ();

  feedback_flanger #(
    .DELAY_DEPTH     (DEPTH),
    .CHANNELS        (CHANNELS),
    .SINE_TABLE_SIZE (SINE_SIZE)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .samples   (sample_bus.sink),
    .results   (result_bus.source),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // flanger model state
  cfg_t               model_cfg;
  logic signed [15:0] sine_rom [SINE_SIZE];
  logic signed [15:0] line_m [CHANNELS][DEPTH];
  logic [9:0]         wr_pos_m [CHANNELS];
  logic [31:0]        lfo_phase_m [CHANNELS];

  flange_out_t pending_outputs [$];

  int  cycles;
  int  samples_sent;
  int  directed_sent;
  int  results_seen;
  int  mismatches;
  int  reg_writes;
  bit  send_burst;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles,
             pending_outputs.size());
    $display("Some tests failed");
    $finish;
  end

  function automatic logic signed [15:0] clip16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // quarter-wave fold and q30 taylor series, rounded to q15
  function automatic logic signed [15:0] sine_entry(input int k);
    logic [63:0] a, r, x, x2, term;
    longint      sum, v;
    int          n;
    a = (64'(k) << 32) / 64'(SINE_SIZE);
    r = a & 64'h3fff_ffff;
    if (a[30]) r = 64'h4000_0000 - r;
    x = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    v = (sum + 16384) >>> 15;
    if (v > 32767) v = 32767;
    if (a[31]) v = -v;
    return 16'(v);
  endfunction

  function automatic void reset_model();
    model_cfg.base_delay    = BASE_DELAY_RST;
    model_cfg.depth_delay   = DEPTH_DELAY_RST;
    model_cfg.phase_step    = PHASE_STEP_RST;
    model_cfg.feedback_gain = FEEDBACK_GAIN_RST;
    model_cfg.manual_offset = MANUAL_OFFSET_RST;
    model_cfg.mix_gain      = MIX_GAIN_RST;
    model_cfg.max_delay     = MAX_DELAY_RST;
    for (int k = 0; k < SINE_SIZE; k++) sine_rom[k] = sine_entry(k);
    for (int c = 0; c < CHANNELS; c++) begin
      wr_pos_m[c] = '0;
      lfo_phase_m[c] = '0;
      for (int i = 0; i < DEPTH; i++) line_m[c][i] = '0;
    end
  endfunction

  function automatic void model_reg_write(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_BASE_DELAY:    model_cfg.base_delay    = data[17:0];
      REG_DEPTH_DELAY:   model_cfg.depth_delay   = data[17:0];
      REG_PHASE_STEP:    model_cfg.phase_step    = data[31:0];
      REG_FEEDBACK_GAIN: model_cfg.feedback_gain = data[15:0];
      REG_MANUAL_OFFSET: model_cfg.manual_offset = data[15:0];
      REG_MIX_GAIN:      model_cfg.mix_gain      = data[15:0];
      REG_MAX_DELAY:     model_cfg.max_delay     = data[17:0];
      default: ;
    endcase
  endfunction

  // one sample through the flanger: modulated delay, interpolated tap,
  // feedback write back, wet/dry mix, lfo advance
  function automatic flange_out_t flange_predict(input logic chb,
                                                 input logic signed [15:0] dry_in);
    int          c, k, wp, i0, i1;
    longint      dry, lfo, upper, d, n, f, x0, x1, wet, fbg, mixg;
    flange_out_t res;
    c = int'(chb) % CHANNELS;
    dry = dry_in;
    k = int'((64'(lfo_phase_m[c]) * 64'(SINE_SIZE)) >> 32);
    lfo = longint'(sine_rom[k]) + longint'($signed(model_cfg.manual_offset));
    upper = longint'(model_cfg.max_delay);
    if (upper > (DEPTH - 1) * 256) upper = (DEPTH - 1) * 256;
    if (upper < 256) upper = 256;
    d = longint'(model_cfg.base_delay)
        + ((longint'(model_cfg.depth_delay) * lfo + 16384) >>> 15);
    if (d < 256) d = 256;
    if (d > upper) d = upper;
    n = d >>> 8;
    f = d & 255;
    wp = int'(wr_pos_m[c]);
    i0 = int'((wp + DEPTH - n) % DEPTH);
    i1 = int'((wp + 2 * DEPTH - n - 1) % DEPTH);
    x0 = line_m[c][i0];
    x1 = line_m[c][i1];
    wet = x0 + ((f * (x1 - x0) + 128) >>> 8);
    fbg = longint'($signed(model_cfg.feedback_gain));
    if (fbg > longint'(FB_LIMIT)) fbg = longint'(FB_LIMIT);
    if (fbg < -longint'(FB_LIMIT)) fbg = -longint'(FB_LIMIT);
    line_m[c][wp] = clip16(((wet * fbg + 16384) >>> 15) + dry);
    wr_pos_m[c] = 10'((wp + 1) % DEPTH);
    mixg = longint'(model_cfg.mix_gain);
    if (mixg > longint'(MIX_FULL)) mixg = longint'(MIX_FULL);
    res.ch = chb;
    res.smp = clip16((wet * mixg + dry * (32768 - mixg) + 16384) >>> 15);
    lfo_phase_m[c] = lfo_phase_m[c] + model_cfg.phase_step;
    return res;
  endfunction

  // register value for a random phase; phase 0 takes the top of every
  // range, phase 1 the bottom
  function automatic logic [31:0] pick_reg(input int phase,
                                           input logic [CFG_INDEX_W-1:0] idx);
    logic [31:0] v;
    v = 32'd0;
    case (idx)
      REG_BASE_DELAY: begin
        if (phase == 0) v = 32'd261888;
        else if (phase == 1) v = 32'd0;
        else if ($urandom_range(0, 3) == 0) v = $urandom_range(0, 262143);
        else v = $urandom_range(256, 40 * 256);
      end
      REG_DEPTH_DELAY: begin
        if (phase == 0) v = 32'd261888;
        else if (phase == 1) v = 32'd0;
        else if ($urandom_range(0, 3) == 0) v = $urandom_range(0, 262143);
        else v = $urandom_range(0, 32 * 256);
      end
      REG_PHASE_STEP: begin
        if (phase == 0) v = 32'hffff_ffff;
        else if (phase == 1) v = 32'd0;
        else if ($urandom_range(0, 1) == 0) v = $urandom;
        else v = $urandom_range(0, 32'h0400_0000);
      end
      REG_FEEDBACK_GAIN: begin
        if (phase == 0) v = 32'd31130;
        else if (phase == 1) v = 32'h0000_8666;
        else if ($urandom_range(0, 3) == 0) v = $urandom & 32'hffff;
        else v = (32'($urandom_range(0, 62260)) - 32'd31130) & 32'hffff;
      end
      REG_MANUAL_OFFSET: begin
        if (phase == 0) v = 32'h0000_7fff;
        else if (phase == 1) v = 32'h0000_8000;
        else if ($urandom_range(0, 2) == 0) v = 32'd0;
        else v = $urandom & 32'hffff;
      end
      REG_MIX_GAIN: begin
        if (phase == 0) v = 32'd32768;
        else if (phase == 1) v = 32'd0;
        else if ($urandom_range(0, 3) == 0) v = $urandom & 32'hffff;
        else v = $urandom_range(0, 32768);
      end
      REG_MAX_DELAY: begin
        if (phase == 0) v = 32'd261888;
        else if (phase == 1) v = 32'd256;
        else if ($urandom_range(0, 3) == 0) v = $urandom & 32'h3ffff;
        else v = $urandom_range(256, 261888);
      end
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 511)) - 16'sd256;
      default: return 16'($urandom);
    endcase
  endfunction

  // wait until every predicted result has arrived, then let the block settle
  task automatic wait_drained(input int settle);
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // one register write, starting at the current falling edge
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    model_reg_write(idx, data);
    reg_writes++;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // offer one sample; valid stays high across back-to-back samples
  task automatic offer_sample(input logic ch, input logic signed [15:0] smp,
                              input logic typed, input logic signed [15:0] want);
    int          gap;
    flange_out_t pred;
    if (samples_sent % 32 == 0) send_burst = ($urandom_range(0, 3) == 0);
    gap = send_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      sample_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_bus.valid     <= 1'b1;
    sample_bus.channel   <= ch;
    sample_bus.sample_in <= smp;
    @(posedge clk);
    while (!sample_bus.ready) @(posedge clk);
    // transfer at this edge: model steps in acceptance order
    pred = flange_predict(ch, smp);
    if (typed) pred.smp = want;
    pending_outputs = {pending_outputs, pred};
    samples_sent++;
    @(negedge clk);
  endtask

  // result sink: random hold-offs, bursts with ready held high, and one long
  // stall so that the output register fills and the input backs up
  initial begin : result_sink
    int          wait_cycles;
    bit          burst;
    bit          held;
    flange_out_t exp_res;
    result_bus.ready = 1'b0;
    burst = 1'b0;
    held = 1'b0;
    @(negedge clk);
    forever begin
      if (results_seen % 32 == 0) burst = ($urandom_range(0, 3) == 0);
      wait_cycles = burst ? 0 : $urandom_range(0, 10);
      if (results_seen == HOLD_AT && !held) begin
        held = 1'b1;
        wait_cycles = HOLD_CYCLES;
      end
      if (wait_cycles > 0) begin
        result_bus.ready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      result_bus.ready <= 1'b1;
      @(posedge clk);
      while (!result_bus.valid) @(posedge clk);
      results_seen++;
      if (pending_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result %0d with nothing pending: ch %0d sample %0d", results_seen,
                   result_bus.channel_out, result_bus.sample_out);
      end else begin
        exp_res = pending_outputs.pop_front();
        if (result_bus.channel_out !== exp_res.ch || result_bus.sample_out !== exp_res.smp)
        begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result %0d mismatch: expected ch %0d sample %0d, got ch %0d sample %0d",
                     results_seen, exp_res.ch, exp_res.smp,
                     result_bus.channel_out, result_bus.sample_out);
        end
      end
      @(negedge clk);
    end
  end

  initial begin : stimulus
    dir_row_t row;
    int       ph;
    int       i;
    int       r;
    logic     single_ch;
    logic     fixed_ch;
    rst = 1'b1;
    sample_bus.valid = 1'b0;
    sample_bus.channel = 1'b0;
    sample_bus.sample_in = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    samples_sent = 0;
    directed_sent = 0;
    results_seen = 0;
    mismatches = 0;
    reg_writes = 0;
    send_burst = 1'b0;
    reset_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table: register rows only once the block has gone idle
    for (r = 0; r < NROWS; r++) begin
      row = dir_rows[r];
      if (row.kind == ROW_CFG) begin
        sample_bus.valid <= 1'b0;
        wait_drained(SETTLE);
        write_reg(row.idx, row.data);
      end else begin
        offer_sample(row.ch, row.smp, row.typed, row.want);
      end
    end
    directed_sent = samples_sent;

    // random phases, each with a full fresh register set
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      sample_bus.valid <= 1'b0;
      wait_drained(SETTLE);
      for (r = 0; r < 7; r++) write_reg(r[CFG_INDEX_W-1:0], pick_reg(ph, r[CFG_INDEX_W-1:0]));
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, $urandom);
      single_ch = ($urandom_range(0, 4) == 0);
      fixed_ch = 1'($urandom);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == PAUSE_PHASE && i == PHASE_ITEMS / 2) begin
          // sender goes quiet until the pipeline is empty
          sample_bus.valid <= 1'b0;
          wait_drained(1);
        end
        offer_sample(single_ch ? fixed_ch : 1'($urandom), rand_sample(), 1'b0, 16'sh0);
      end
    end

    sample_bus.valid <= 1'b0;
    wait_drained(TAIL);

    $display("covered %0d samples (%0d directed) across %0d register writes, %0d results",
             samples_sent, directed_sent, reg_writes, results_seen);
    $display("delay clamps, feedback saturation, lfo extremes and a long sink stall included; "
             , "%0d mismatches", mismatches);
    if (mismatches == 0 && pending_outputs.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
